// File: rtl/pidpc_pkg.sv
// Package for the PID position controller: field widths, register
// indexes, reset values and the drive limit.
// No dependencies.
package pidpc_pkg;

  localparam int POS_W      = 16;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int INTEG_W    = 34;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 51;
  localparam int REM_W      = 26;
  localparam int QUOT_W     = 10;
  localparam int DUTY_W     = 11;
  localparam int DRIVE_W    = 11;
  localparam int OFFS_W     = 10;
  localparam int PERIOD_W   = 7;
  localparam int SLOT_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 4;

  localparam int CAPTURE_DEPTH_DEF = 128;

  localparam logic [QUOT_W-1:0] DRIVE_LIMIT = 10'd516;
  // Quotients at or above this multiple of the divisor saturate.
  localparam logic [INTEG_W-1:0] SAT_MULT = 34'd517;

  localparam logic [COEF_W-1:0]   RST_GAIN_PROP      = 16'd560;
  localparam logic [COEF_W-1:0]   RST_GAIN_INTEG     = 16'd3;
  localparam logic [COEF_W-1:0]   RST_GAIN_DERIV     = 16'd10;
  localparam logic [OFFS_W-1:0]   RST_DUTY_OFFSET    = 10'd0;
  localparam logic [COEF_W-1:0]   RST_GAIN_DIVISOR   = 16'd100;
  localparam logic [COEF_W-1:0]   RST_INTEG_BOUND    = 16'd100;
  localparam logic [COEF_W-1:0]   RST_DEAD_BAND      = 16'd8;
  localparam logic [PERIOD_W-1:0] RST_CAPTURE_PERIOD = 7'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP      = 3'd0,
    REG_GAIN_INTEG     = 3'd1,
    REG_GAIN_DERIV     = 3'd2,
    REG_DUTY_OFFSET    = 3'd3,
    REG_GAIN_DIVISOR   = 3'd4,
    REG_INTEG_BOUND    = 3'd5,
    REG_DEAD_BAND      = 3'd6,
    REG_CAPTURE_PERIOD = 3'd7
  } cfg_reg_t;

endpackage

// File: rtl/pidpc_in_if.sv
// Input channel of the PID position controller: one beat per control tick.
// Depends on pidpc_pkg.
interface pidpc_in_if
  import pidpc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] measured_position;
  logic [POS_W-1:0] target_position;

  modport source (output valid, output measured_position, output target_position,
                  input ready);
  modport sink (input valid, input measured_position, input target_position,
                output ready);
endinterface

// File: rtl/pidpc_out_if.sv
// Result channel of the PID position controller: one beat per control tick.
// Depends on pidpc_pkg.
interface pidpc_out_if
  import pidpc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      direction;
  logic [DUTY_W-1:0]         duty;
  logic signed [DRIVE_W-1:0] drive;
  logic                      capture_strobe;
  logic [SLOT_W-1:0]         capture_slot;

  modport source (output valid, output direction, output duty, output drive,
                  output capture_strobe, output capture_slot, input ready);
  modport sink (input valid, input direction, input duty, input drive,
                input capture_strobe, input capture_slot, output ready);
endinterface

// File: rtl/pidpc_cfg_if.sv
// Configuration write channel of the PID position controller.
// Depends on pidpc_pkg.
interface pidpc_cfg_if
  import pidpc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/pid_position_controller.sv
// PID position controller. Once a tick beat is accepted the block is busy
// and takes the next beat the cycle after its result is loaded into the
// output register; when the PID sum is zero or its quotient saturates
// the ten divider steps are skipped. The busy time is set by one shared
// 17 x 34 bit multiplier, used five times per tick
// (integral limit, three PID terms, saturation threshold), and by a
// restoring divider that resolves one quotient bit per cycle. A result
// waiting in the output register holds the sequencer only at its last step.
// Configuration writes are always taken and must occur while idle.
// Depends on pidpc_pkg and the three channel interfaces.
module pid_position_controller
  import pidpc_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pidpc_in_if.sink    in_ch,
  pidpc_out_if.source out_ch,
  pidpc_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (CAPTURE_DEPTH > 2) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPTURE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LIM, S_CLMP, S_PI, S_PD, S_PS, S_ABS, S_CMP, S_DIV, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [COEF_W-1:0]   gain_prop_r, gain_integ_r, gain_deriv_r, gain_divisor_r;
  logic [COEF_W-1:0]   integ_bound_r, dead_band_r;
  logic [OFFS_W-1:0]   duty_offset_r;
  logic [PERIOD_W-1:0] capture_period_r;

  // Controller state.
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_error_r;
  logic [PERIOD_W-1:0]       phase_r;
  logic [IDX_W-1:0]          index_r;

  // Per-tick working registers.
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0]        mag_r;
  logic                     sign_r;
  logic [REM_W-1:0]         rem_r;
  logic [QUOT_W-1:0]        quot_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  // Output register.
  logic                      out_valid_r;
  logic                      direction_r;
  logic [DUTY_W-1:0]         duty_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      strobe_r;
  logic [SLOT_W-1:0]         slot_r;

  // Shared multiplier operands and product.
  logic [COEF_W-1:0]         mul_a;
  logic signed [INTEG_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;

  always_comb begin
    mul_a = gain_prop_r;
    mul_b = INTEG_W'(err_r);
    unique case (state_r)
      S_LIM: begin
        mul_a = integ_bound_r;
        mul_b = $signed(INTEG_W'(gain_integ_r));
      end
      S_CLMP: begin
        mul_a = gain_prop_r;
        mul_b = INTEG_W'(err_r);
      end
      S_PI: begin
        mul_a = gain_integ_r;
        mul_b = integ_r;
      end
      S_PD: begin
        mul_a = gain_deriv_r;
        mul_b = INTEG_W'(diff_r);
      end
      S_PS: begin
        mul_a = gain_divisor_r;
        mul_b = $signed(SAT_MULT);
      end
      default: begin
        mul_a = gain_prop_r;
        mul_b = INTEG_W'(err_r);
      end
    endcase
    prod_nxt = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);
  end

  // Integral update with clamping to the limit held in prod_r.
  logic signed [INTEG_W-1:0] lim_pos, lim_neg, integ_sum, integ_nxt;

  always_comb begin
    lim_pos   = $signed({1'b0, prod_r[INTEG_W-2:0]});
    lim_neg   = -lim_pos;
    integ_sum = integ_r + INTEG_W'(err_r);
    integ_nxt = integ_sum;
    if (integ_sum > lim_pos) begin
      integ_nxt = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ_nxt = lim_neg;
    end
  end

  // One restoring division step.
  logic [REM_W-1:0] div_shift;
  logic [REM_W:0]   div_trial;

  always_comb begin
    div_shift = REM_W'(gain_divisor_r) << div_cnt_r;
    div_trial = {1'b0, rem_r} - {1'b0, div_shift};
  end

  // Result assembly for the last step.
  logic [ERR_W-1:0]          abs_err;
  logic [DRIVE_W-1:0]        drive_mag;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic [DUTY_W-1:0]         duty_nxt;
  logic [PERIOD_W-1:0]       phase_inc;
  logic                      strobe_nxt;

  always_comb begin
    abs_err    = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    drive_mag  = {1'b0, quot_r};
    drive_nxt  = sign_r ? $signed(~drive_mag + 1'b1) : $signed(drive_mag);
    duty_nxt   = (abs_err > {1'b0, dead_band_r})
                 ? DUTY_W'(quot_r) + DUTY_W'(duty_offset_r) : '0;
    phase_inc  = phase_r + 1'b1;
    strobe_nxt = (phase_inc == capture_period_r);
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.direction      = direction_r;
  assign out_ch.duty           = duty_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.capture_strobe = strobe_r;
  assign out_ch.capture_slot   = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      integ_r          <= '0;
      prev_error_r     <= '0;
      phase_r          <= '0;
      index_r          <= '0;
      gain_prop_r      <= RST_GAIN_PROP;
      gain_integ_r     <= RST_GAIN_INTEG;
      gain_deriv_r     <= RST_GAIN_DERIV;
      duty_offset_r    <= RST_DUTY_OFFSET;
      gain_divisor_r   <= RST_GAIN_DIVISOR;
      integ_bound_r    <= RST_INTEG_BOUND;
      dead_band_r      <= RST_DEAD_BAND;
      capture_period_r <= RST_CAPTURE_PERIOD;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_GAIN_PROP:      gain_prop_r      <= cfg_ch.data;
          REG_GAIN_INTEG:     gain_integ_r     <= cfg_ch.data;
          REG_GAIN_DERIV:     gain_deriv_r     <= cfg_ch.data;
          REG_DUTY_OFFSET:    duty_offset_r    <= cfg_ch.data[OFFS_W-1:0];
          REG_GAIN_DIVISOR:   gain_divisor_r   <= cfg_ch.data;
          REG_INTEG_BOUND:    integ_bound_r    <= cfg_ch.data;
          REG_DEAD_BAND:      dead_band_r      <= cfg_ch.data;
          REG_CAPTURE_PERIOD: capture_period_r <= cfg_ch.data[PERIOD_W-1:0];
          default:            gain_prop_r      <= gain_prop_r;
        endcase
      end

      // In the last step the result load below decides the valid flag.
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            err_r   <= $signed({1'b0, in_ch.target_position})
                       - $signed({1'b0, in_ch.measured_position});
            state_r <= S_LIM;
          end
        end
        S_LIM: begin
          prod_r       <= prod_nxt;
          diff_r       <= DIFF_W'(err_r) - DIFF_W'(prev_error_r);
          prev_error_r <= err_r;
          state_r      <= S_CLMP;
        end
        S_CLMP: begin
          integ_r <= integ_nxt;
          prod_r  <= prod_nxt;
          state_r <= S_PI;
        end
        S_PI: begin
          acc_r   <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= S_PD;
        end
        S_PD: begin
          acc_r   <= acc_r + prod_r;
          prod_r  <= prod_nxt;
          state_r <= S_PS;
        end
        S_PS: begin
          acc_r   <= acc_r + prod_r;
          prod_r  <= prod_nxt;
          state_r <= S_ABS;
        end
        S_ABS: begin
          sign_r  <= acc_r[PROD_W-1];
          mag_r   <= acc_r[PROD_W-1] ? PROD_W'(-acc_r) : PROD_W'(acc_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          // A zero sum gives zero drive; a quotient past the limit (or a
          // zero divisor) saturates without dividing.
          if (mag_r == '0) begin
            quot_r  <= '0;
            state_r <= S_FIN;
          end else if (mag_r >= $unsigned(prod_r)) begin
            quot_r  <= DRIVE_LIMIT;
            state_r <= S_FIN;
          end else begin
            rem_r     <= mag_r[REM_W-1:0];
            quot_r    <= '0;
            div_cnt_r <= DIV_CNT_W'(QUOT_W - 1);
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_trial[REM_W]) begin
            rem_r             <= div_trial[REM_W-1:0];
            quot_r[div_cnt_r] <= 1'b1;
          end
          if (div_cnt_r == '0) begin
            state_r <= S_FIN;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            direction_r <= sign_r && (quot_r != '0);
            duty_r      <= duty_nxt;
            drive_r     <= drive_nxt;
            strobe_r    <= strobe_nxt;
            if (strobe_nxt) begin
              phase_r <= '0;
              slot_r  <= SLOT_W'(index_r);
              index_r <= (index_r == IDX_LAST) ? '0 : index_r + 1'b1;
            end else begin
              phase_r <= phase_inc;
              slot_r  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive <= 11'sd516 && out_ch.drive >= -11'sd516))
    else $error("drive outside the clamp range");

  a_direction_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.direction == out_ch.drive[DRIVE_W-1]))
    else $error("direction disagrees with the drive sign");

  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.capture_strobe) |-> (out_ch.capture_slot == '0))
    else $error("capture slot set without a strobe");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new tick taken while the previous one is in work");

endmodule

// File: dv/tb_pid_position_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_position_controller: drives control ticks and
// register writes, predicts every result beat and checks it field by field.
// Depends on pidpc_pkg, the three channel interfaces and the controller RTL.
module tb_pid_position_controller
  import pidpc_pkg::*;
;

  typedef struct {
    logic [POS_W-1:0] meas;
    logic [POS_W-1:0] tgt;
  } tick_t;

  typedef struct {
    logic                      direction;
    logic [DUTY_W-1:0]         duty;
    logic signed [DRIVE_W-1:0] drive;
    logic                      capture_strobe;
    logic [SLOT_W-1:0]         capture_slot;
  } ctrl_out_t;

  logic clk = 1'b0;
  logic rst_n;

  pidpc_in_if  in_if ();
  pidpc_out_if out_if ();
  pidpc_cfg_if cfg_if ();

  pid_position_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #2 clk = ~clk;

  // Register copy used for prediction.
  logic [COEF_W-1:0]   kp_reg, ki_reg, kd_reg, kdiv_reg, ibound_reg, dband_reg;
  logic [OFFS_W-1:0]   offset_reg;
  logic [PERIOD_W-1:0] period_reg;

  // Controller state copy.
  longint integ_acc;
  longint last_err;
  int     cap_phase;
  int     cap_index;

  tick_t     tick_q[$];
  ctrl_out_t ctrl_out_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches    = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int strobes_seen  = 0;
  int saturated     = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  function automatic void apply_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_GAIN_PROP:      kp_reg     = val;
      REG_GAIN_INTEG:     ki_reg     = val;
      REG_GAIN_DERIV:     kd_reg     = val;
      REG_DUTY_OFFSET:    offset_reg = val[OFFS_W-1:0];
      REG_GAIN_DIVISOR:   kdiv_reg   = val;
      REG_INTEG_BOUND:    ibound_reg = val;
      REG_DEAD_BAND:      dband_reg  = val;
      REG_CAPTURE_PERIOD: period_reg = val[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // One control tick: clamped integral, PID sum, divide, clamp, duty and capture.
  function automatic ctrl_out_t compute_control(logic [POS_W-1:0] meas, logic [POS_W-1:0] tgt);
    longint m, t, err, limit, diff, sum, drv, mag, abs_err, kp, ki, kd, kdiv, lim_drv;
    longint duty;
    ctrl_out_t r;
    m = longint'(meas);
    t = longint'(tgt);
    kp = longint'(kp_reg);
    ki = longint'(ki_reg);
    kd = longint'(kd_reg);
    kdiv = longint'(kdiv_reg);
    lim_drv = longint'(DRIVE_LIMIT);
    err = t - m;
    limit = longint'(ibound_reg);
    limit = limit * ki;
    integ_acc = integ_acc + err;
    if (integ_acc > limit) integ_acc = limit;
    if (integ_acc < -limit) integ_acc = -limit;
    diff = err - last_err;
    last_err = err;
    sum = kp * err + ki * integ_acc + kd * diff;
    if (kdiv == 0) begin
      drv = (sum > 0) ? lim_drv : ((sum < 0) ? -lim_drv : 0);
    end else begin
      drv = sum / kdiv;
    end
    if (drv > lim_drv) drv = lim_drv;
    if (drv < -lim_drv) drv = -lim_drv;
    mag = (drv < 0) ? -drv : drv;
    abs_err = (err < 0) ? -err : err;
    duty = (abs_err > longint'(dband_reg)) ? mag + longint'(offset_reg) : 0;
    r.capture_strobe = 1'b0;
    r.capture_slot = '0;
    cap_phase = (cap_phase + 1) & 127;
    if (cap_phase == int'(period_reg)) begin
      cap_phase = 0;
      r.capture_strobe = 1'b1;
      r.capture_slot = cap_index[SLOT_W-1:0];
      cap_index = cap_index + 1;
      if (cap_index >= CAPTURE_DEPTH_DEF) cap_index = 0;
    end
    r.direction = (drv < 0);
    r.duty = duty[DUTY_W-1:0];
    r.drive = drv[DRIVE_W-1:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[POS_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cfg(cfg_reg_t r, int style);
    int roll;
    logic [CFG_DATA_W-1:0] hi, typ;
    roll = $urandom_range(0, 7);
    case (r)
      REG_GAIN_PROP: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(0, 1200));
      end
      REG_GAIN_INTEG: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(0, 60));
      end
      REG_GAIN_DERIV: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(0, 300));
      end
      REG_DUTY_OFFSET: begin
        hi = 16'd1023; typ = CFG_DATA_W'($urandom_range(0, 1023));
      end
      REG_GAIN_DIVISOR: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(1, 400));
      end
      REG_INTEG_BOUND: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(0, 3000));
      end
      REG_DEAD_BAND: begin
        hi = 16'hFFFF; typ = CFG_DATA_W'($urandom_range(0, 64));
      end
      default: begin
        hi = 16'd127;  typ = CFG_DATA_W'($urandom_range(1, 16));
      end
    endcase
    if (style == 1) return hi;
    if (style == 2) return '0;
    if (roll == 0) return '0;
    if (roll == 1) return hi;
    if (roll == 2 && r == REG_GAIN_DIVISOR) return 16'd1;
    return typ;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    apply_cfg(idx, val);
    cfg_writes++;
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_tick(logic [POS_W-1:0] meas, logic [POS_W-1:0] tgt);
    tick_t t;
    t.meas = meas;
    t.tgt = tgt;
    tick_q.push_back(t);
  endtask

  // The sender pauses here until every result of the queued ticks is back.
  task automatic wait_idle();
    do @(negedge clk); while (tick_q.size() != 0 || in_if.valid || ctrl_out_q.size() != 0);
  endtask

  // Mostly a set point that wanders with the position tracking it at a
  // varying distance, with jumps to the range ends and some pure noise.
  task automatic queue_random_ticks(int n);
    int tgt, meas, scale, roll;
    scale = 32;
    tgt = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 3))
          0:       scale = 4;
          1:       scale = 40;
          2:       scale = 400;
          default: scale = 5000;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        tgt = int'(clamp_pos(tgt + int'($urandom_range(0, 2 * scale)) - scale));
        meas = tgt + int'($urandom_range(0, 2 * scale)) - scale;
      end else if (roll < 88) begin
        case ($urandom_range(0, 2))
          0:       tgt = 0;
          1:       tgt = 65535;
          default: tgt = $urandom_range(0, 65535);
        endcase
        meas = tgt + int'($urandom_range(0, 2 * scale)) - scale;
      end else begin
        tgt = $urandom_range(0, 65535);
        meas = $urandom_range(0, 65535);
      end
      queue_tick(clamp_pos(meas), clamp_pos(tgt));
    end
  endtask

  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        ctrl_out_q.push_back(compute_control(in_if.measured_position, in_if.target_position));
        ticks_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          in_if.valid             <= 1'b1;
          in_if.measured_position <= nxt.meas;
          in_if.target_position   <= nxt.tgt;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    ctrl_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (ctrl_out_q.size() == 0) begin
        report_mismatch("result beat with no tick pending", 1, 0);
      end else begin
        want = ctrl_out_q.pop_front();
        if (out_if.direction !== want.direction)
          report_mismatch("direction", out_if.direction, want.direction);
        if (out_if.duty !== want.duty)
          report_mismatch("duty", out_if.duty, want.duty);
        if (out_if.drive !== want.drive)
          report_mismatch("drive", out_if.drive, want.drive);
        if (out_if.capture_strobe !== want.capture_strobe)
          report_mismatch("capture_strobe", out_if.capture_strobe, want.capture_strobe);
        if (out_if.capture_slot !== want.capture_slot)
          report_mismatch("capture_slot", out_if.capture_slot, want.capture_slot);
        if (want.capture_strobe) strobes_seen++;
        if (want.drive == 11'sd516 || want.drive == -11'sd516) saturated++;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : stimulus
    int style;
    logic [CFG_DATA_W-1:0] val;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.measured_position = '0;
    in_if.target_position = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    send_idle_pct = 19;
    recv_idle_pct = 55;
    kp_reg = RST_GAIN_PROP;
    ki_reg = RST_GAIN_INTEG;
    kd_reg = RST_GAIN_DERIV;
    offset_reg = RST_DUTY_OFFSET;
    kdiv_reg = RST_GAIN_DIVISOR;
    ibound_reg = RST_INTEG_BOUND;
    dband_reg = RST_DEAD_BAND;
    period_reg = RST_CAPTURE_PERIOD;
    integ_acc = 0;
    last_err = 0;
    cap_phase = 0;
    cap_index = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: field extremes and both edges of the dead band.
    queue_tick(16'd0, 16'd0);
    queue_tick(16'hFFFF, 16'd0);
    queue_tick(16'd0, 16'hFFFF);
    queue_tick(16'hFFFF, 16'hFFFF);
    queue_tick(16'd1000, 16'd1008);
    queue_tick(16'd1000, 16'd1009);
    queue_tick(16'd1000, 16'd991);
    queue_tick(16'h5555, 16'hAAAA);
    wait_idle();

    // Zero divisor saturates by sign; zero integral gain clamps the integral to zero.
    write_reg(REG_GAIN_DIVISOR, 16'd0);
    write_reg(REG_GAIN_INTEG, 16'd0);
    queue_tick(16'd5, 16'd10);
    queue_tick(16'd10, 16'd5);
    queue_tick(16'd7, 16'd7);
    queue_tick(16'd7, 16'd7);
    wait_idle();

    // Build a large integral, then shrink the bound under it.
    write_reg(REG_GAIN_INTEG, 16'hFFFF);
    write_reg(REG_INTEG_BOUND, 16'hFFFF);
    write_reg(REG_GAIN_DIVISOR, 16'hFFFF);
    queue_tick(16'd0, 16'hFFFF);
    queue_tick(16'd0, 16'hFFFF);
    queue_tick(16'd0, 16'd40000);
    wait_idle();
    write_reg(REG_INTEG_BOUND, 16'd1);
    queue_tick(16'd0, 16'd0);
    wait_idle();

    // Advance the capture phase; the first random setting lowers the period below it.
    write_reg(REG_CAPTURE_PERIOD, 16'd50);
    queue_random_ticks(8);

    for (int k = 0; k < 12; k++) begin
      if (k == 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 19;
      end
      if (k == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      style = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      for (int r = 0; r < 8; r++) begin
        val = pick_cfg(cfg_reg_t'(r), style);
        if (k == 0 && cfg_reg_t'(r) == REG_CAPTURE_PERIOD) val = 16'd3;
        write_reg(cfg_reg_t'(r), val);
      end
      queue_random_ticks(130);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (ctrl_out_q.size() != 0) report_mismatch("ticks without a result", ctrl_out_q.size(), 0);
    $display("Sent %0d control ticks with %0d register writes; checked %0d result beats.",
             ticks_sent, cfg_writes, results_seen);
    $display("Covered %0d capture strobes and %0d saturated drives; %0d mismatches.",
             strobes_seen, saturated, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Timeout waiting for the controller.");
    $display("Some tests failed");
    $finish;
  end

endmodule
